// ===== src/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and arithmetic helpers for the pressure and
// temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W     = 20;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int MID_DEPTH_DEF = 16;
    localparam int OUT_DEPTH_DEF = 32;

    // quotient bits resolved by each divider stage
    localparam int DIV_BITS = 8;

    localparam logic [63:0] FINE_OFFS = 64'd128000;
    localparam logic [63:0] P_BASE    = 64'd1048576;
    localparam logic [63:0] P_SCALE   = 64'd3125;
    localparam logic [63:0] ONE_47    = 64'h0000_8000_0000_0000;
    localparam logic [31:0] ROUND_HALF = 32'd128;

    localparam logic [CFG_IDX_W-1:0] IDX_T1_T2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_T3_P1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_P2_P3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_P4_P5 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_P6_P7 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_P8_P9 = 3'd5;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] temp;
        logic [19:0] adc_p;
    } mid_item_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        dz;
    } out_item_t;

    function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sx64(input logic signed [15:0] v);
        return 64'(v);
    endfunction

endpackage

// ===== src/ptc_fifo.sv =====
// ----------------------------------------------------------------------------
// ptc_fifo
// Small register-file queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module ptc_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        level_next = level_reg + LVL_W'(push) - LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

// ===== src/ptc_mul.sv =====
// ----------------------------------------------------------------------------
// ptc_mul
// 64 x 64 multiplier with registered partial products and low 64-bit product.
// ----------------------------------------------------------------------------
module ptc_mul (
    input  logic        clk,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);
    logic [63:0] ll_reg;
    logic [31:0] hl_reg;
    logic [31:0] lh_reg;

    // low 64 bits only need the cross terms modulo 2^32
    always_ff @(posedge clk)
    begin
        ll_reg <= a[31:0] * b[31:0];
        hl_reg <= a[63:32] * b[31:0];
        lh_reg <= a[31:0] * b[63:32];
        p      <= ll_reg + {hl_reg + lh_reg, 32'd0};
    end

endmodule

// ===== src/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front
// Accepts raw sample pairs and computes fine temperature and temperature.
// ----------------------------------------------------------------------------
module ptc_front #(
    parameter int MID_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [ptc_pkg::RAW_W-1:0]    raw_temperature,
    input  logic [ptc_pkg::RAW_W-1:0]    raw_pressure,
    input  ptc_pkg::cal_t                cal,
    input  logic                         mid_pop,
    output logic                         mid_push,
    output ptc_pkg::mid_item_t           mid_item
);
    import ptc_pkg::*;

    localparam int CNT_W = $clog2(MID_DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [5:0]       vld_reg;
    logic             accept;

    logic [19:0] adc_t_reg;
    logic [19:0] adcp_reg [6];
    logic [17:0] d1, d1_reg;
    logic [16:0] d2, d2_reg;
    logic signed [33:0] pa_full, dd_full;
    logic signed [47:0] pb_full;
    logic [31:0] pa_reg, dd_reg, a_reg, pb_reg, fine_reg, fine5_reg, temp_reg;

    // count every request in flight or queued so the middle queue never overflows
    assign full   = (cnt_reg == CNT_W'(MID_DEPTH));
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + CNT_W'(accept) - CNT_W'(mid_pop);
            vld_reg <= {vld_reg[4:0], accept};
        end
    end

    assign d1      = {1'b0, adc_t_reg[19:3]} - {1'b0, cal.t1, 1'b0};
    assign d2      = {1'b0, adc_t_reg[19:4]} - {1'b0, cal.t1};
    assign pa_full = $signed(d1_reg) * cal.t2;
    assign dd_full = $signed(d2_reg) * $signed(d2_reg);
    assign pb_full = $signed(sra32(dd_reg, 12)) * cal.t3;

    always_ff @(posedge clk)
    begin
        adc_t_reg   <= raw_temperature;
        adcp_reg[0] <= raw_pressure;
        for (int i = 1; i < 6; i++)
        begin
            adcp_reg[i] <= adcp_reg[i-1];
        end
        d1_reg    <= d1;
        d2_reg    <= d2;
        pa_reg    <= pa_full[31:0];
        dd_reg    <= dd_full[31:0];
        a_reg     <= sra32(pa_reg, 11);
        pb_reg    <= pb_full[31:0];
        fine_reg  <= a_reg + sra32(pb_reg, 14);
        fine5_reg <= fine_reg;
        temp_reg  <= sra32(fine_reg + (fine_reg << 2) + ROUND_HALF, 8);
    end

    assign mid_push       = vld_reg[5];
    assign mid_item.fine  = fine5_reg;
    assign mid_item.temp  = temp_reg;
    assign mid_item.adc_p = adcp_reg[5];

endmodule

// ===== src/ptc_back.sv =====
// ----------------------------------------------------------------------------
// ptc_back
// Pressure pipeline: 64-bit polynomial terms, pipelined signed divider and
// final correction, issued only against free output queue space.
// ----------------------------------------------------------------------------
module ptc_back #(
    parameter int OUT_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptc_pkg::cal_t        cal,
    input  logic                 mid_empty,
    input  ptc_pkg::mid_item_t   mid_item,
    output logic                 mid_pop,
    input  logic                 out_pop,
    output logic                 out_push,
    output ptc_pkg::out_item_t   out_item
);
    import ptc_pkg::*;

    localparam int OCNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int DIV_STAGES = 64 / DIV_BITS;
    localparam int S_MAG      = 10;
    localparam int S_Q        = S_MAG + 1 + DIV_STAGES;
    localparam int S_OUT      = S_Q + 5;

    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] nq;
    } div_state_t;

    function automatic div_state_t div_step(input div_state_t s, input logic [31:0] md);
        logic [32:0] r;
        div_state_t  o;
        o = s;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            r    = {o.rem, o.nq[63]};
            o.nq = {o.nq[62:0], 1'b0};
            if (r >= {1'b0, md})
            begin
                r       = r - {1'b0, md};
                o.nq[0] = 1'b1;
            end
            o.rem = r[31:0];
        end
        return o;
    endfunction

    logic [OCNT_W-1:0] ocnt_reg;
    logic [S_OUT:1]    vld_reg;
    logic              launch;

    logic [31:0] temp_dly_reg [1:S_OUT];
    logic [19:0] adcp_dly_reg [1:6];
    logic        zero_dly_reg [S_MAG:S_OUT];
    logic        neg_dly_reg  [S_MAG:S_Q-1];
    logic [31:0] md_dly_reg   [S_MAG:S_Q-1];
    logic [63:0] m5_dly_reg   [4:5];
    logic [63:0] m2_dly_reg   [4:5];
    logic [63:0] q_dly_reg    [S_Q:S_Q+4];
    logic [63:0] p8q_dly_reg  [S_Q+3:S_Q+4];
    div_state_t  div_reg      [DIV_STAGES];

    logic [63:0] v1_reg, v2_reg, x47_reg, pn_reg, den_reg, mn_reg, sum_reg;
    logic [63:0] sq, m5, m2, v2a, m3, dm, num, ph2, p8q, t9, ph;
    logic [63:0] pfin, pres64;
    div_state_t  div_in;

    // admit a request only when the output queue has room for it
    assign launch  = !mid_empty && (ocnt_reg < OCNT_W'(OUT_DEPTH));
    assign mid_pop = launch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            ocnt_reg <= ocnt_reg + OCNT_W'(launch) - OCNT_W'(out_pop);
            vld_reg  <= {vld_reg[S_OUT-1:1], launch};
        end
    end

    ptc_mul u_mul_sq  (.clk(clk), .a(v1_reg),  .b(v1_reg),            .p(sq));
    ptc_mul u_mul_p5  (.clk(clk), .a(v1_reg),  .b(sx64(cal.p5)),      .p(m5));
    ptc_mul u_mul_p2  (.clk(clk), .a(v1_reg),  .b(sx64(cal.p2)),      .p(m2));
    ptc_mul u_mul_p6  (.clk(clk), .a(sq),      .b(sx64(cal.p6)),      .p(v2a));
    ptc_mul u_mul_p3  (.clk(clk), .a(sq),      .b(sx64(cal.p3)),      .p(m3));
    ptc_mul u_mul_p1  (.clk(clk), .a(x47_reg), .b({48'd0, cal.p1}),   .p(dm));
    ptc_mul u_mul_sc  (.clk(clk), .a(pn_reg),  .b(P_SCALE),           .p(num));
    ptc_mul u_mul_ph  (.clk(clk), .a(ph),      .b(ph),                .p(ph2));
    ptc_mul u_mul_p8  (.clk(clk), .a(q_dly_reg[S_Q]), .b(sx64(cal.p8)), .p(p8q));
    ptc_mul u_mul_p9  (.clk(clk), .a(ph2),     .b(sx64(cal.p9)),      .p(t9));

    assign ph         = sra64(q_dly_reg[S_Q], 13);
    assign div_in.rem = '0;
    assign div_in.nq  = mn_reg;

    always_ff @(posedge clk)
    begin
        temp_dly_reg[1] <= mid_item.temp;
        for (int i = 2; i <= S_OUT; i++)
        begin
            temp_dly_reg[i] <= temp_dly_reg[i-1];
        end
        adcp_dly_reg[1] <= mid_item.adc_p;
        for (int i = 2; i <= 6; i++)
        begin
            adcp_dly_reg[i] <= adcp_dly_reg[i-1];
        end

        v1_reg <= {{32{mid_item.fine[31]}}, mid_item.fine} - FINE_OFFS;

        m5_dly_reg[4] <= m5;
        m5_dly_reg[5] <= m5_dly_reg[4];
        m2_dly_reg[4] <= m2;
        m2_dly_reg[5] <= m2_dly_reg[4];

        v2_reg  <= v2a + (m5_dly_reg[5] << 17) + (sx64(cal.p4) << 35);
        x47_reg <= ONE_47 + sra64(m3, 8) + (m2_dly_reg[5] << 12);
        pn_reg  <= ((P_BASE - {44'd0, adcp_dly_reg[6]}) << 31) - v2_reg;
        den_reg <= sra64(dm, 33);

        // split into magnitudes and sign for the unsigned divider
        mn_reg              <= num[63] ? 64'd0 - num : num;
        md_dly_reg[S_MAG]   <= den_reg[63] ? 32'(64'd0 - den_reg) : den_reg[31:0];
        neg_dly_reg[S_MAG]  <= num[63] ^ den_reg[63];
        zero_dly_reg[S_MAG] <= (den_reg == 64'd0);
        for (int i = S_MAG + 1; i < S_Q; i++)
        begin
            md_dly_reg[i]  <= md_dly_reg[i-1];
            neg_dly_reg[i] <= neg_dly_reg[i-1];
        end
        for (int i = S_MAG + 1; i <= S_OUT; i++)
        begin
            zero_dly_reg[i] <= zero_dly_reg[i-1];
        end

        div_reg[0] <= div_step(div_in, md_dly_reg[S_MAG]);
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            div_reg[i] <= div_step(div_reg[i-1], md_dly_reg[S_MAG+i]);
        end

        q_dly_reg[S_Q] <= neg_dly_reg[S_Q-1] ? 64'd0 - div_reg[DIV_STAGES-1].nq
                                             : div_reg[DIV_STAGES-1].nq;
        for (int i = S_Q + 1; i <= S_Q + 4; i++)
        begin
            q_dly_reg[i] <= q_dly_reg[i-1];
        end
        p8q_dly_reg[S_Q+3] <= p8q;
        p8q_dly_reg[S_Q+4] <= p8q_dly_reg[S_Q+3];

        sum_reg <= q_dly_reg[S_Q+4] + sra64(t9, 25) + sra64(p8q_dly_reg[S_Q+4], 19);
    end

    assign pfin   = sra64(sum_reg, 8) + (sx64(cal.p7) << 4);
    assign pres64 = sra64(pfin, 8);

    assign out_push       = vld_reg[S_OUT];
    assign out_item.temp  = temp_dly_reg[S_OUT];
    assign out_item.press = zero_dly_reg[S_OUT] ? 32'd0 : pres64[31:0];
    assign out_item.dz    = zero_dly_reg[S_OUT];

endmodule

// ===== src/pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Calibrated temperature and pressure from raw converter sample pairs.
// ----------------------------------------------------------------------------
// The block takes one raw temperature/pressure pair per clock while full is
// low and returns one result per pair in order, through queue-style ports on
// both sides. A pair passes the temperature pipeline, a queue, then the
// pressure pipeline, whose length is set by the pipelined 64-bit multiplier
// units and the 8-stage divider (8 quotient bits per stage). A full output
// queue backs up into the middle queue and then into full. Calibration
// registers are to be written through the cfg port while no request is in
// flight; the user must keep to this, the block does not enforce it. Indexes above five are ignored.
module pressure_temp_compensation #(
    parameter int MID_DEPTH = ptc_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = ptc_pkg::OUT_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [ptc_pkg::RAW_W-1:0]         raw_temperature,
    input  logic [ptc_pkg::RAW_W-1:0]         raw_pressure,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [ptc_pkg::WORD_W-1:0] temp_hundredths,
    output logic [ptc_pkg::WORD_W-1:0]        pressure_pascal,
    output logic                              divisor_zero,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptc_pkg::WORD_W-1:0]        cfg_data
);
    import ptc_pkg::*;

    localparam int MID_W = $bits(mid_item_t);
    localparam int OUT_W = $bits(out_item_t);

    logic [31:0] cal_t1_t2_reg, cal_t3_p1_reg, cal_p2_p3_reg;
    logic [31:0] cal_p4_p5_reg, cal_p6_p7_reg, cal_p8_p9_reg;
    cal_t        cal;

    logic        mid_push, mid_pop, mid_empty;
    mid_item_t   mid_wr, mid_rd;
    logic [MID_W-1:0] mid_rdata;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_level;

    logic        out_push, out_pop;
    out_item_t   out_wr, out_rd;
    logic [OUT_W-1:0] out_rdata;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_t1_t2_reg <= '0;
            cal_t3_p1_reg <= '0;
            cal_p2_p3_reg <= '0;
            cal_p4_p5_reg <= '0;
            cal_p6_p7_reg <= '0;
            cal_p8_p9_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                IDX_T1_T2: cal_t1_t2_reg <= cfg_data;
                IDX_T3_P1: cal_t3_p1_reg <= cfg_data;
                IDX_P2_P3: cal_p2_p3_reg <= cfg_data;
                IDX_P4_P5: cal_p4_p5_reg <= cfg_data;
                IDX_P6_P7: cal_p6_p7_reg <= cfg_data;
                IDX_P8_P9: cal_p8_p9_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        cal.t1 = cal_t1_t2_reg[15:0];
        cal.t2 = cal_t1_t2_reg[31:16];
        cal.t3 = cal_t3_p1_reg[15:0];
        cal.p1 = cal_t3_p1_reg[31:16];
        cal.p2 = cal_p2_p3_reg[15:0];
        cal.p3 = cal_p2_p3_reg[31:16];
        cal.p4 = cal_p4_p5_reg[15:0];
        cal.p5 = cal_p4_p5_reg[31:16];
        cal.p6 = cal_p6_p7_reg[15:0];
        cal.p7 = cal_p6_p7_reg[31:16];
        cal.p8 = cal_p8_p9_reg[15:0];
        cal.p9 = cal_p8_p9_reg[31:16];
    end

    ptc_front #(.MID_DEPTH(MID_DEPTH)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .cal             (cal),
        .mid_pop         (mid_pop),
        .mid_push        (mid_push),
        .mid_item        (mid_wr)
    );

    ptc_fifo #(.DEPTH(MID_DEPTH), .WIDTH(MID_W)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wr),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .level (mid_level)
    );

    assign mid_rd = mid_item_t'(mid_rdata);

    ptc_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal),
        .mid_empty (mid_empty),
        .mid_item  (mid_rd),
        .mid_pop   (mid_pop),
        .out_pop   (out_pop),
        .out_push  (out_push),
        .out_item  (out_wr)
    );

    assign out_pop = pop && !empty;

    ptc_fifo #(.DEPTH(OUT_DEPTH), .WIDTH(OUT_W)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wr),
        .pop   (out_pop),
        .rdata (out_rdata),
        .empty (empty),
        .level (out_level)
    );

    assign out_rd          = out_item_t'(out_rdata);
    assign temp_hundredths = out_rd.temp;
    assign pressure_pascal = out_rd.press;
    assign divisor_zero    = out_rd.dz;

    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> (mid_level < MID_DEPTH))
        else $error("middle queue written while full");

    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_level < OUT_DEPTH))
        else $error("output queue written while full");

    a_zero_div_press: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && divisor_zero) |-> (pressure_pascal == '0))
        else $error("nonzero pressure with zero divisor");

endmodule

// ===== dv/pressure_temp_compensation_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation_test
// Drives raw temperature/pressure pairs through the compensation block under
// several calibration sets and compares every result field by field with a
// compensation predictor in the bench or, for typed rows, with fixed values.
// Both sides idle and stall at random; a long output stall backs up into full.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_test;
    import ptc_pkg::*;

    localparam int SETTLE     = 48;     // cycles past the last result
    localparam int STALL_LEN  = 300;    // long output hold-off
    localparam int STUCK_MAX  = 3000;   // cycles with no handshake on any port
    localparam int RAND_ITEMS = 97;     // random pairs for most calibration sets
    localparam int NUM_REGS   = 6;

    typedef struct {
        logic [31:0] temp;
        logic [31:0] press;
        logic        dz;
    } comp_t;

    typedef struct {
        logic [19:0] rt;
        logic [19:0] rp;
        bit          typed;
        comp_t       want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [19:0] raw_temperature = '0;
    logic [19:0] raw_pressure = '0;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        full;
    logic        empty;
    logic signed [31:0] temp_hundredths;
    logic [31:0] pressure_pascal;
    logic        divisor_zero;
    logic        cfg_ready;

    logic [31:0] cal_word [NUM_REGS];
    comp_t       pending_q [$];
    int          errors = 0;
    int          n_results = 0;
    int          stuck_cycles = 0;
    bit          held = 1'b0;
    int          hold_left = 0;
    bit          calm;

    // idling pauses on both sides while these results drain
    assign calm = (n_results >= 300) && (n_results < 450);

    pressure_temp_compensation dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
        .empty(empty), .pop(pop),
        .temp_hundredths(temp_hundredths), .pressure_pascal(pressure_pascal),
        .divisor_zero(divisor_zero),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
        logic [31:0] r;
        r = $signed(x) >>> n;
        return r;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
        logic [63:0] r;
        r = $signed(x) >>> n;
        return r;
    endfunction

    function automatic logic [63:0] sext16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // signed division truncating toward zero
    function automatic logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
        logic [63:0] mn, md, q;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        q = mn / md;
        return (num[63] != den[63]) ? -q : q;
    endfunction

    function automatic comp_t compensate(logic [19:0] rt, logic [19:0] rp);
        logic [31:0] t1, t2, t3, d1, d2, a, b, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, ph, fine64;
        comp_t r;
        t1 = {16'h0, cal_word[IDX_T1_T2][15:0]};
        t2 = {{16{cal_word[IDX_T1_T2][31]}}, cal_word[IDX_T1_T2][31:16]};
        t3 = {{16{cal_word[IDX_T3_P1][15]}}, cal_word[IDX_T3_P1][15:0]};
        d1 = {15'h0, rt[19:3]} - (t1 << 1);
        a = asr32(d1 * t2, 11);
        d2 = {16'h0, rt[19:4]} - t1;
        b = asr32(asr32(d2 * d2, 12) * t3, 14);
        fine = a + b;
        r.temp = asr32(fine * 32'd5 + 32'd128, 8);

        p1 = {48'h0, cal_word[IDX_T3_P1][31:16]};
        p2 = sext16(cal_word[IDX_P2_P3][15:0]);
        p3 = sext16(cal_word[IDX_P2_P3][31:16]);
        p4 = sext16(cal_word[IDX_P4_P5][15:0]);
        p5 = sext16(cal_word[IDX_P4_P5][31:16]);
        p6 = sext16(cal_word[IDX_P6_P7][15:0]);
        p7 = sext16(cal_word[IDX_P6_P7][31:16]);
        p8 = sext16(cal_word[IDX_P8_P9][15:0]);
        p9 = sext16(cal_word[IDX_P8_P9][31:16]);
        fine64 = {{32{fine[31]}}, fine};

        v1 = fine64 - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        r.press = '0;
        r.dz = 1'b1;
        if (v1 != 0)
        begin
            p = 64'd1048576 - {44'h0, rp};
            p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
            ph = asr64(p, 13);
            v1 = asr64(p9 * ph * ph, 25);
            v2 = asr64(p8 * p, 19);
            p = asr64(p + v1 + v2, 8) + (p7 << 4);
            p = asr64(p, 8);
            r.press = p[31:0];
            r.dz = 1'b0;
        end
        return r;
    endfunction

    task automatic send_pair(logic [19:0] rt, logic [19:0] rp, bit typed, comp_t want);
        int gap;
        if (!calm && $urandom_range(99) < 13)
        begin
            gap = $urandom_range(4, 1);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        raw_temperature <= rt;
        raw_pressure <= rp;
        do @(posedge clk); while (full);
        pending_q.push_back(typed ? want : compensate(rt, rp));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS)
            cal_word[idx] = data;
    endtask

    task automatic load_cal(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                            logic [31:0] w3, logic [31:0] w4, logic [31:0] w5);
        write_reg(IDX_T1_T2, w0);
        write_reg(IDX_T3_P1, w1);
        write_reg(IDX_P2_P3, w2);
        write_reg(IDX_P4_P5, w3);
        write_reg(IDX_P6_P7, w4);
        write_reg(IDX_P8_P9, w5);
    endtask

    task automatic random_pairs(int n);
        logic [19:0] rt, rp;
        comp_t none;
        none = '{default: '0};
        repeat (n)
        begin
            case ($urandom_range(3))
                0:
                begin
                    rt = 20'($urandom());
                    rp = 20'($urandom());
                end
                1:
                begin
                    rt = 20'($urandom_range(600000, 400000));
                    rp = 20'($urandom_range(700000, 200000));
                end
                2:
                begin
                    rt = $urandom_range(1) ? 20'hFFFFF : 20'h0;
                    rp = 20'($urandom());
                end
                default:
                begin
                    rt = 20'($urandom());
                    rp = $urandom_range(1) ? 20'hFFFFF : 20'h0;
                end
            endcase
            send_pair(rt, rp, 1'b0, none);
        end
    endtask

    // typical calibration words: T1..T3, P1..P9
    localparam logic [31:0] TYP0 = {16'd26435, 16'd27504};
    localparam logic [31:0] TYP1 = {16'd36477, 16'hFC18};
    localparam logic [31:0] TYP2 = {16'd3024, 16'hD643};
    localparam logic [31:0] TYP3 = {16'd140, 16'd2855};
    localparam logic [31:0] TYP4 = {16'd15500, 16'hFFF9};
    localparam logic [31:0] TYP5 = {16'd6000, 16'hC6F8};

    // first rows run on reset calibration: zero fine temperature, zero divisor
    stim_row_t stim_table [] = '{
        '{20'h00000, 20'h00000, 1'b1, '{32'd0, 32'd0, 1'b1}},
        '{20'hFFFFF, 20'hFFFFF, 1'b1, '{32'd0, 32'd0, 1'b1}},
        '{20'h00000, 20'hFFFFF, 1'b1, '{32'd0, 32'd0, 1'b1}},
        '{20'hFFFFF, 20'h00000, 1'b1, '{32'd0, 32'd0, 1'b1}},
        '{20'h5A5A5, 20'hA5A5A, 1'b1, '{32'd0, 32'd0, 1'b1}},
        '{20'd519888, 20'd415148, 1'b0, '{default: '0}},
        '{20'h00000, 20'h00000, 1'b0, '{default: '0}},
        '{20'hFFFFF, 20'hFFFFF, 1'b0, '{default: '0}},
        '{20'h00000, 20'hFFFFF, 1'b0, '{default: '0}},
        '{20'hFFFFF, 20'h00000, 1'b0, '{default: '0}},
        '{20'd430000, 20'd300000, 1'b0, '{default: '0}},
        '{20'd600000, 20'd600000, 1'b0, '{default: '0}},
        '{20'h55555, 20'hAAAAA, 1'b0, '{default: '0}}
    };

    // output side: check each popped result, randomly stall, one long hold
    initial
    begin
        comp_t want;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: result with no request: temp %0d press %0d dz %0b",
                             $time, temp_hundredths, pressure_pascal, divisor_zero);
                    errors++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (temp_hundredths !== want.temp)
                    begin
                        $display("%0t: temp_hundredths expected %0d actual %0d", $time,
                                 $signed(want.temp), temp_hundredths);
                        errors++;
                    end
                    if (pressure_pascal !== want.press)
                    begin
                        $display("%0t: pressure_pascal expected %0d actual %0d", $time,
                                 want.press, pressure_pascal);
                        errors++;
                    end
                    if (divisor_zero !== want.dz)
                    begin
                        $display("%0t: divisor_zero expected %0b actual %0b", $time,
                                 want.dz, divisor_zero);
                        errors++;
                    end
                end
                n_results++;
            end
            if (!held && n_results >= 150)
            begin
                held = 1'b1;
                hold_left = STALL_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= calm || ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_MAX)
            begin
                $display("%0t: no progress for %0d cycles", $time, stuck_cycles);
                $display("pressure_temp_compensation_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_REGS; i++)
            cal_word[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (i > 0 && stim_table[i - 1].typed && !stim_table[i].typed)
            begin
                drain();
                load_cal(TYP0, TYP1, TYP2, TYP3, TYP4, TYP5);
            end
            send_pair(stim_table[i].rt, stim_table[i].rp, stim_table[i].typed,
                      stim_table[i].want);
        end
        random_pairs(RAND_ITEMS);

        // out-of-range indexes must leave the calibration alone
        drain();
        write_reg(3'd6, $urandom());
        write_reg(3'd7, $urandom());
        random_pairs(20);

        drain();
        load_cal('1, '1, '1, '1, '1, '1);
        random_pairs(RAND_ITEMS);

        drain();
        load_cal(32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                 32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
        random_pairs(RAND_ITEMS);

        drain();
        load_cal(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        random_pairs(RAND_ITEMS);

        // P1 of zero forces a zero divisor with live temperature
        drain();
        load_cal(TYP0, {16'h0, TYP1[15:0]}, TYP2, TYP3, TYP4, TYP5);
        random_pairs(40);

        repeat (4)
        begin
            drain();
            load_cal($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            random_pairs(RAND_ITEMS);
        end

        drain();
        if (errors == 0)
            $display("pressure_temp_compensation_test OK");
        else
            $display("pressure_temp_compensation_test NOT OK");
        $finish;
    end

endmodule
